FILE: rtl/pair_distance_histogram_assert.svh
// assertion macros for the pair distance histogram
// used by rtl modules that check their own control logic
`ifndef PAIR_DISTANCE_HISTOGRAM_ASSERT_SVH
`define PAIR_DISTANCE_HISTOGRAM_ASSERT_SVH
`ifndef SYNTHESIS
`define PHD_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define PHD_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define PHD_ASSERT_NOW(name, clk, rst, ante, cons)
`define PHD_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/phd_pkg.sv
// shared types and constants of the pair distance histogram
// no dependencies
`timescale 1ns / 1ps
package phd_pkg;
   typedef enum logic [1:0] {
      OP_ACC   = 2'd0,
      OP_READ  = 2'd1,
      OP_CLEAR = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      REG_BOX_X     = 2'd0,
      REG_BOX_Y     = 2'd1,
      REG_BOX_Z     = 2'd2,
      REG_BIN_WIDTH = 2'd3
   } reg_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_SQ,
      B_MUL,
      B_CMP,
      B_FIN,
      B_RD
   } back_state_type;

   localparam int COORD_BITS = 32;
   localparam int DIST_BITS  = 66;

   typedef struct packed {
      logic [1:0]           op;
      logic [DIST_BITS-1:0] dist_sq;
      logic [5:0]           read_bin;
   } work_type;

   typedef struct packed {
      logic        pair_counted;
      logic [5:0]  bin_number;
      logic [31:0] bin_count;
   } result_type;
endpackage

FILE: rtl/phd_queue.sv
// small first-in first-out queue between pipeline parts
// depends on nothing
`timescale 1ns / 1ps
module phd_queue #(
   parameter int W     = 8,
   parameter int DEPTH = 2
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  logic [W-1:0] wr_data,
   output logic         full,
   input  logic         pop,
   output logic [W-1:0] rd_data,
   output logic         empty
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [W-1:0]  mem [DEPTH];
   logic [PW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0] count_ff;
   logic          do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end
endmodule

FILE: rtl/phd_front.sv
// front pipeline: minimum image, squares and squared distance per item
// depends on phd_pkg
`timescale 1ns / 1ps
module phd_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_stall,
   input  logic [1:0]        in_op,
   input  logic [31:0]       first [3],
   input  logic [31:0]       second [3],
   input  logic [5:0]        in_read_bin,
   input  logic [31:0]       box [3],
   output logic              work_push,
   output phd_pkg::work_type work_data,
   input  logic              work_full
);
   logic              advance;
   logic              v1_ff, v2_ff, v3_ff, v4_ff;
   logic [1:0]        op1_ff, op2_ff, op3_ff, op4_ff;
   logic [5:0]        rb1_ff, rb2_ff, rb3_ff, rb4_ff;
   logic signed [35:0] d1_in [3];
   logic signed [35:0] d1_ff [3];
   logic signed [35:0] d2_tmp [3];
   logic [31:0]       m_in [3];
   logic [31:0]       m_ff [3];
   logic [63:0]       sq_ff [3];
   logic [65:0]       sum_ff;

   assign advance   = !v4_ff || !work_full;
   assign in_stall  = !advance;
   assign work_push = v4_ff && !work_full;
   assign work_data = '{op: op4_ff, dist_sq: sum_ff, read_bin: rb4_ff};

   for (genvar a = 0; a < 3; a++) begin : g_axis
      logic signed [35:0] d0, len;
      assign len = 36'(box[a]);
      assign d0  = 36'(second[a]) - 36'(first[a]);
      assign d1_in[a] = ((d0 <<< 1) >= len) ? d0 - len : d0;
      assign d2_tmp[a] = ((d1_ff[a] <<< 1) < -len) ? d1_ff[a] + len : d1_ff[a];
      assign m_in[a] = d2_tmp[a][35] ? 32'(-d2_tmp[a]) : d2_tmp[a][31:0];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         op1_ff <= in_op;
         rb1_ff <= in_read_bin;
         op2_ff <= op1_ff;
         rb2_ff <= rb1_ff;
         op3_ff <= op2_ff;
         rb3_ff <= rb2_ff;
         op4_ff <= op3_ff;
         rb4_ff <= rb3_ff;
         for (int a = 0; a < 3; a++) begin
            d1_ff[a] <= d1_in[a];
            m_ff[a]  <= m_in[a];
            sq_ff[a] <= m_ff[a] * m_ff[a];
         end
         sum_ff <= 66'(sq_ff[0]) + 66'(sq_ff[1]) + 66'(sq_ff[2]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end
endmodule

FILE: rtl/phd_back.sv
// back end: bin search by shared multiplier, histogram store, read and clear
// depends on phd_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "pair_distance_histogram_assert.svh"
module phd_back #(
   parameter int NUM_BINS   = 64,
   parameter int COUNT_BITS = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  phd_pkg::work_type   work_data,
   input  logic                work_empty,
   output logic                work_pop,
   input  logic [63:0]         width_sq,
   output logic                out_push,
   output phd_pkg::result_type out_data,
   input  logic                out_full
);
   localparam int BW  = $clog2(NUM_BINS + 1);
   localparam int SW  = 2 * BW;
   localparam int PRW = SW + 64;
   localparam int AW  = $clog2(NUM_BINS);
   localparam int TW  = (BW > 1) ? $clog2(BW) : 1;

   phd_pkg::back_state_type state_ff, state_in;

   logic [COUNT_BITS-1:0] mem [NUM_BINS];
   logic [NUM_BINS-1:0]   valid_ff;
   logic [COUNT_BITS-1:0] rd_data_ff;
   logic                  rd_valid_ff;
   logic                  rd_en, wr_en, clr_all;
   logic [AW-1:0]         rd_addr;
   logic [COUNT_BITS-1:0] wr_data, cnt;

   logic [1:0]          op_ff, op_in;
   logic [65:0]         s_ff, s_in;
   logic [5:0]          rb_ff, rb_in;
   logic [BW-1:0]       b_ff, b_in, cand_ff, cand_in, cand;
   logic [TW-1:0]       bit_ff, bit_in;
   logic                ok_ff, ok_in;
   logic [SW-1:0]       sq_ff, sq_in;
   logic [SW+31:0]      pl_ff, ph_ff;
   logic [PRW-1:0]      prod;
   logic [15:0]         rb_ext, b_ext;
   logic [47:0]         cnt_ext;

   assign cand    = b_ff | (BW'(1) << bit_ff);
   assign prod    = PRW'(pl_ff) + (PRW'(ph_ff) << 32);
   assign rb_ext  = 16'(rb_ff);
   assign b_ext   = 16'(b_ff);
   assign cnt     = rd_valid_ff ? rd_data_ff : '0;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[b_ff[AW-1:0]] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      s_ff    <= s_in;
      rb_ff   <= rb_in;
      cand_ff <= cand_in;
      ok_ff   <= ok_in;
      sq_ff   <= sq_in;
      pl_ff   <= sq_ff * width_sq[31:0];
      ph_ff   <= sq_ff * width_sq[63:32];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= phd_pkg::B_IDLE;
         valid_ff <= '0;
         b_ff     <= '0;
         bit_ff   <= '0;
      end else begin
         state_ff <= state_in;
         b_ff     <= b_in;
         bit_ff   <= bit_in;
         if (clr_all) begin
            valid_ff <= '0;
         end else if (wr_en) begin
            valid_ff[b_ff[AW-1:0]] <= 1'b1;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      s_in     = s_ff;
      rb_in    = rb_ff;
      b_in     = b_ff;
      bit_in   = bit_ff;
      cand_in  = cand_ff;
      ok_in    = ok_ff;
      sq_in    = sq_ff;
      work_pop = 1'b0;
      rd_en    = 1'b0;
      rd_addr  = b_ff[AW-1:0];
      wr_en    = 1'b0;
      wr_data  = (cnt == '1) ? cnt : cnt + 1'b1;
      clr_all  = 1'b0;
      out_push = 1'b0;
      cnt_ext  = 48'(wr_data);
      out_data = '0;
      case (state_ff)
         phd_pkg::B_IDLE: begin
            if (!work_empty) begin
               work_pop = 1'b1;
               op_in    = work_data.op;
               s_in     = work_data.dist_sq;
               rb_in    = work_data.read_bin;
               b_in     = '0;
               bit_in   = TW'(BW - 1);
               if (work_data.op == phd_pkg::OP_ACC) begin
                  state_in = phd_pkg::B_SQ;
               end else if (work_data.op == phd_pkg::OP_READ) begin
                  rd_en    = 1'b1;
                  rd_addr  = AW'(work_data.read_bin);
                  state_in = phd_pkg::B_RD;
               end else begin
                  state_in = phd_pkg::B_FIN;
               end
            end
         end
         phd_pkg::B_SQ: begin
            cand_in  = cand;
            ok_in    = (cand <= BW'(NUM_BINS));
            sq_in    = cand * cand;
            state_in = phd_pkg::B_MUL;
         end
         phd_pkg::B_MUL: begin
            state_in = phd_pkg::B_CMP;
         end
         phd_pkg::B_CMP: begin
            if (ok_ff && (prod <= PRW'(s_ff))) begin
               b_in = cand_ff;
            end
            if (bit_ff == '0) begin
               state_in = phd_pkg::B_FIN;
            end else begin
               bit_in   = bit_ff - 1'b1;
               state_in = phd_pkg::B_SQ;
            end
         end
         phd_pkg::B_FIN: begin
            if (op_ff == phd_pkg::OP_ACC && b_ff != BW'(NUM_BINS)) begin
               rd_en    = 1'b1;
               state_in = phd_pkg::B_RD;
            end else if (!out_full) begin
               out_push = 1'b1;
               clr_all  = (op_ff == phd_pkg::OP_CLEAR);
               state_in = phd_pkg::B_IDLE;
            end
         end
         phd_pkg::B_RD: begin
            if (!out_full) begin
               out_push = 1'b1;
               state_in = phd_pkg::B_IDLE;
               if (op_ff == phd_pkg::OP_ACC) begin
                  wr_en    = 1'b1;
                  out_data = '{pair_counted: 1'b1, bin_number: b_ext[5:0],
                               bin_count: cnt_ext[31:0]};
               end else begin
                  cnt_ext  = 48'(cnt);
                  out_data.bin_number = rb_ff;
                  if (rb_ext < 16'(NUM_BINS)) begin
                     out_data.bin_count = cnt_ext[31:0];
                  end
               end
            end
         end
         default: begin
            state_in = phd_pkg::B_IDLE;
         end
      endcase
   end

   `PHD_ASSERT_NOW(a_push_room, clock, reset, out_push, !out_full)
   `PHD_ASSERT_NOW(a_bin_range, clock, reset, 1'b1, b_ff <= BW'(NUM_BINS))
   `PHD_ASSERT_NEXT(a_clear_all, clock, reset, clr_all, valid_ff == '0)
   `PHD_ASSERT_NOW(a_pop_idle, clock, reset, work_pop, state_ff == phd_pkg::B_IDLE)
endmodule

FILE: rtl/pair_distance_histogram.sv
// pair distance histogram top level: registers, front pipeline, queues, back end
// depends on phd_pkg, phd_queue, phd_front and phd_back
//
// usage: items enter on the req_ queue port (push while full is low), results
// leave on the rsp_ queue port (data valid while empty is low, pop to take it)
// csr_ writes set box_x, box_y, box_z and bin_width; csr_ready is always high
// op 0 accumulates a pair, op 1 reads one bin, op 2 clears all bins
// every item gives exactly one result, in order
// an item passes the 4 front stages and the work queue into the back end, and
// its result passes the result queue to the rsp_ port; the back end takes one
// item at a time: an accumulate runs B_SQ, B_MUL and B_CMP for each bit of the
// bin search ($clog2(NUM_BINS+1) bits, each on the shared multiplier), then
// B_FIN and, inside the cutoff, B_RD; a read runs B_RD, a clear B_FIN
// full rises once the work queue is full and the last front stage is valid, so
// a stream of accumulates sees full most of the time; a stalled receiver fills
// the result queue and holds the back end, and the rest backs up behind it
// reset clears all bins at once (per-bin valid flags), box lengths to zero
// and bin_width to one; no clearing pass is needed
`timescale 1ns / 1ps
module pair_distance_histogram #(
   parameter int NUM_BINS   = 64,
   parameter int COUNT_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [1:0]  req_op,
   input  logic [31:0] req_first_x,
   input  logic [31:0] req_first_y,
   input  logic [31:0] req_first_z,
   input  logic [31:0] req_second_x,
   input  logic [31:0] req_second_y,
   input  logic [31:0] req_second_z,
   input  logic [5:0]  req_read_bin,
   output logic        empty,
   input  logic        pop,
   output logic        rsp_pair_counted,
   output logic [5:0]  rsp_bin_number,
   output logic [31:0] rsp_bin_count,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);
   logic [31:0] box_ff [3];
   logic [31:0] width_ff;
   logic [63:0] width_sq_ff;
   logic [31:0] first [3];
   logic [31:0] second [3];

   logic                work_push, work_full, work_pop, work_empty;
   phd_pkg::work_type   work_in, work_out;
   logic                out_push, out_full;
   phd_pkg::result_type out_in, out_out;

   assign csr_ready = 1'b1;
   assign first  = '{req_first_x, req_first_y, req_first_z};
   assign second = '{req_second_x, req_second_y, req_second_z};

   always_ff @(posedge clock) begin
      if (reset) begin
         box_ff      <= '{32'd0, 32'd0, 32'd0};
         width_ff    <= 32'd1;
         width_sq_ff <= 64'd1;
      end else begin
         width_sq_ff <= width_ff * width_ff;
         if (csr_valid) begin
            case (phd_pkg::reg_type'(csr_index))
               phd_pkg::REG_BOX_X:     box_ff[0] <= csr_data;
               phd_pkg::REG_BOX_Y:     box_ff[1] <= csr_data;
               phd_pkg::REG_BOX_Z:     box_ff[2] <= csr_data;
               phd_pkg::REG_BIN_WIDTH: width_ff  <= csr_data;
               default: ;
            endcase
         end
      end
   end

   phd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (push && !full),
      .in_stall    (full),
      .in_op       (req_op),
      .first       (first),
      .second      (second),
      .in_read_bin (req_read_bin),
      .box         (box_ff),
      .work_push   (work_push),
      .work_data   (work_in),
      .work_full   (work_full)
   );

   phd_queue #(.W($bits(phd_pkg::work_type)), .DEPTH(2)) u_work_q (
      .clock   (clock),
      .reset   (reset),
      .push    (work_push),
      .wr_data (work_in),
      .full    (work_full),
      .pop     (work_pop),
      .rd_data (work_out),
      .empty   (work_empty)
   );

   phd_back #(.NUM_BINS(NUM_BINS), .COUNT_BITS(COUNT_BITS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .work_data  (work_out),
      .work_empty (work_empty),
      .work_pop   (work_pop),
      .width_sq   (width_sq_ff),
      .out_push   (out_push),
      .out_data   (out_in),
      .out_full   (out_full)
   );

   phd_queue #(.W($bits(phd_pkg::result_type)), .DEPTH(2)) u_rsp_q (
      .clock   (clock),
      .reset   (reset),
      .push    (out_push),
      .wr_data (out_in),
      .full    (out_full),
      .pop     (pop),
      .rd_data (out_out),
      .empty   (empty)
   );

   assign rsp_pair_counted = out_out.pair_counted;
   assign rsp_bin_number   = out_out.bin_number;
   assign rsp_bin_count    = out_out.bin_count;
endmodule
